// ===== src/pdc_pkg.sv =====
package pdc_pkg;

  typedef enum logic [2:0] {
    OP_ALLOC  = 3'd0,
    OP_FREE   = 3'd1,
    OP_QUERY  = 3'd2,
    OP_LREAD  = 3'd3,
    OP_LWRITE = 3'd4,
    OP_RREAD  = 3'd5,
    OP_RINV   = 3'd6,
    OP_RRDEX  = 3'd7
  } opcode_t;

  localparam logic [1:0] KIND_REPLY  = 2'd0;
  localparam logic [1:0] KIND_NET    = 2'd1;
  localparam logic [1:0] KIND_SIGNAL = 2'd2;

  localparam logic [1:0] NET_READ = 2'd0;
  localparam logic [1:0] NET_INV  = 2'd1;
  localparam logic [1:0] NET_RDEX = 2'd2;

  localparam logic [1:0] ST_INV = 2'd0;
  localparam logic [1:0] ST_RO  = 2'd1;
  localparam logic [1:0] ST_RW  = 2'd2;

  localparam logic [10:0] SIG_RO  = 11'd1;
  localparam logic [10:0] SIG_INV = 11'd4;

  localparam int MAX_MSGS = 7;

  localparam logic CFG_MY_NODE    = 1'b0;
  localparam logic CFG_NODE_COUNT = 1'b1;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [6:0]  page;
    logic [2:0]  from_node;
    logic [19:0] req_size;
    logic [19:0] peer_size;
    logic [7:0]  peer_presence;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  net_op;
    logic [2:0]  target_node;
    logic [1:0]  page_state;
    logic [19:0] page_size;
    logic        valid_here;
    logic [10:0] signal_code;
    logic        send_data;
    logic        last;
  } out_t;

endpackage

// ===== src/pdc_ram.sv =====
module pdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/page_directory_coherence_unit.sv =====
// An input is accepted, its entry read from RAM and the operation executed before the first result.
// A new input is taken only once all results of the last one are out; a local fault walks the
//   live nodes one per cycle while the output does not stall; a client signal precedes the reply.
// Slot-in-use bits are flip-flops cleared at once by rst; the entry RAM is not
//   cleared (entries are written by allocation before use). Reset: my_node 1, node_count 1.
module page_directory_coherence_unit #(
  parameter int TABLE_DEPTH = 128,
  parameter int MAX_NODES   = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pdc_pkg::in_t          in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pdc_pkg::out_t         out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [0:0]            cfg_index,
  input  logic [3:0]            cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int EW = 2 + MAX_NODES + 20;
  localparam int NW = $clog2(MAX_NODES + 1);
  localparam int IW = $clog2(MAX_NODES);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_MSG, S_PUT} state_t;

  state_t                state;
  pdc_pkg::in_t          req;
  logic [2:0]            my_node;
  logic [3:0]            node_count;
  logic [TABLE_DEPTH-1:0] slot_used;
  logic [EW-1:0]         rd_entry;
  logic [EW-1:0]         wr_entry;
  logic                  wr_en;
  logic [1:0]            cur_state;
  logic [MAX_NODES-1:0]  cur_pres;
  logic [19:0]           cur_size;
  logic [1:0]            new_state;
  logic [MAX_NODES-1:0]  new_pres;
  logic [MAX_NODES-1:0]  msg_pres;
  logic [1:0]            msg_op;
  logic [IW-1:0]         scan;
  logic [2:0]            msg_cnt;
  logic                  sig_pending;
  logic [10:0]           sig_code;
  logic                  send_data;
  logic                  in_range;
  logic                  used_now;
  logic [NW-1:0]         live;
  logic [MAX_NODES-1:0]  live_mask;
  logic [MAX_NODES-1:0]  me_bit;
  logic [MAX_NODES-1:0]  from_bit;
  logic [MAX_NODES-1:0]  pres_calc;
  logic [1:0]            state_calc;
  logic [19:0]           size_calc;
  logic [AW-1:0]         slot;
  logic                  out_busy;
  logic                  scan_hit;
  logic                  scan_end;
  logic [10:0]           page_x10;
  logic [19:0]           cur_size_q;
  logic                  live_op;
  logic                  keep;
  logic                  msg_emit;
  logic                  emit;
  pdc_pkg::out_t         out_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_busy  = out_valid && !out_ready;
  assign slot      = req.page[AW-1:0];
  assign in_range  = ({25'd0, req.page} < 32'(TABLE_DEPTH));
  assign used_now  = in_range && slot_used[slot];
  assign page_x10  = {1'b0, req.page, 3'b000} + {3'b000, req.page, 1'b0};
  assign live_op   = in_range && (used_now || (req.opcode == pdc_pkg::OP_ALLOC));
  assign keep      = live_op && (req.opcode != pdc_pkg::OP_FREE);

  always_comb begin
    live = (32'(node_count) > 32'(MAX_NODES)) ? NW'(MAX_NODES) : NW'(node_count);
    for (int i = 0; i < MAX_NODES; i++) begin
      live_mask[i] = (NW'(i) < live);
      me_bit[i]    = (32'(my_node) == i);
      from_bit[i]  = (32'(req.from_node) == i);
    end
  end

  pdc_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_entry_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (slot),
    .wdata (wr_entry),
    .raddr (in_ready ? in_data.page[AW-1:0] : slot),
    .rdata (rd_entry)
  );

  assign cur_state = rd_entry[EW-1 -: 2];
  assign cur_pres  = rd_entry[20 +: MAX_NODES];
  assign cur_size  = rd_entry[19:0];

  always_comb begin
    pres_calc  = cur_pres;
    state_calc = cur_state;
    size_calc  = cur_size;
    case (pdc_pkg::opcode_t'(req.opcode))
      pdc_pkg::OP_ALLOC: begin
        pres_calc = MAX_NODES'(req.peer_presence) & live_mask & ~me_bit;
        if (req.peer_size == 20'd0) begin
          pres_calc  = pres_calc | me_bit;
          state_calc = pdc_pkg::ST_RW;
          size_calc  = req.req_size;
        end else begin
          state_calc = pdc_pkg::ST_INV;
          size_calc  = req.peer_size;
        end
      end
      pdc_pkg::OP_LREAD: begin
        pres_calc  = cur_pres | me_bit;
        state_calc = pdc_pkg::ST_RO;
      end
      pdc_pkg::OP_LWRITE: begin
        pres_calc  = me_bit;
        state_calc = pdc_pkg::ST_RW;
      end
      pdc_pkg::OP_RREAD: begin
        pres_calc  = cur_pres | from_bit;
        state_calc = pdc_pkg::ST_RO;
      end
      pdc_pkg::OP_RINV, pdc_pkg::OP_RRDEX: begin
        pres_calc  = from_bit;
        state_calc = pdc_pkg::ST_INV;
      end
      default: ;
    endcase
  end

  assign wr_en    = (state == S_EXEC) && used_now && (req.opcode != pdc_pkg::OP_FREE)
                    && (req.opcode != pdc_pkg::OP_QUERY) || (state == S_EXEC) && in_range
                    && (req.opcode == pdc_pkg::OP_ALLOC);
  assign wr_entry = {state_calc, pres_calc, size_calc};

  assign scan_hit = msg_pres[scan] && live_mask[scan] && !me_bit[scan];
  assign scan_end = (32'(scan) == MAX_NODES - 1) || (NW'(scan) + NW'(1) >= live);
  assign msg_emit = (state == S_MSG) && !out_busy && scan_hit
                    && (32'(msg_cnt) < pdc_pkg::MAX_MSGS);
  assign emit     = msg_emit || ((state == S_PUT) && !out_busy);

  always_comb begin
    out_next = '0;
    if (state == S_MSG) begin
      out_next.result_kind = pdc_pkg::KIND_NET;
      out_next.net_op      = msg_op;
      out_next.target_node = 3'(scan);
    end else if (sig_pending) begin
      out_next.result_kind = pdc_pkg::KIND_SIGNAL;
      out_next.signal_code = sig_code;
    end else begin
      out_next.result_kind = pdc_pkg::KIND_REPLY;
      out_next.page_state  = new_state;
      out_next.page_size   = cur_size_q;
      out_next.valid_here  = |(new_pres & me_bit);
      out_next.send_data   = send_data;
      out_next.last        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      slot_used <= '0;
      my_node   <= 3'd1;
      node_count <= 4'd1;
    end else begin
      if (cfg_valid) begin
        if (cfg_index[0] == pdc_pkg::CFG_MY_NODE) my_node <= cfg_data[2:0];
        else node_count <= cfg_data;
      end
      if (emit) begin
        out_valid <= 1'b1;
        out_data  <= out_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req   <= in_data;
            state <= S_READ;
          end
        end
        S_READ: state <= S_EXEC;
        S_EXEC: begin
          msg_pres    <= cur_pres;
          scan        <= '0;
          msg_cnt     <= '0;
          new_state   <= keep ? state_calc : pdc_pkg::ST_INV;
          new_pres    <= keep ? pres_calc : '0;
          cur_size_q  <= keep ? size_calc : '0;
          msg_op      <= (req.opcode == pdc_pkg::OP_LREAD) ? pdc_pkg::NET_READ :
                         (cur_state == pdc_pkg::ST_RO) ? pdc_pkg::NET_INV : pdc_pkg::NET_RDEX;
          send_data   <= live_op && ((req.opcode == pdc_pkg::OP_RREAD)
                                     || (req.opcode == pdc_pkg::OP_RRDEX));
          sig_pending <= live_op && ((req.opcode == pdc_pkg::OP_RINV)
                                     || (req.opcode == pdc_pkg::OP_RRDEX)
                                     || ((req.opcode == pdc_pkg::OP_RREAD)
                                         && (cur_state != pdc_pkg::ST_RO)));
          sig_code    <= ((req.opcode == pdc_pkg::OP_RREAD) ? pdc_pkg::SIG_RO
                                                             : pdc_pkg::SIG_INV) + page_x10;
          state       <= (live_op && ((req.opcode == pdc_pkg::OP_LREAD)
                                      || (req.opcode == pdc_pkg::OP_LWRITE))) ? S_MSG : S_PUT;
          if (live_op && (req.opcode == pdc_pkg::OP_ALLOC)) slot_used[slot] <= 1'b1;
          else if (live_op && (req.opcode == pdc_pkg::OP_FREE)) slot_used[slot] <= 1'b0;
        end
        S_MSG: begin
          if (!out_busy) begin
            if (msg_emit) msg_cnt <= msg_cnt + 3'd1;
            if (scan_end) state <= S_PUT;
            else scan <= scan + IW'(1);
          end
        end
        S_PUT: begin
          if (!out_busy) begin
            if (sig_pending) sig_pending <= 1'b0;
            else state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("input accepted while busy");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && out_valid) |-> out_data.last)
    else $error("pending non-final result while idle");
  a_msg_cap: assert property (@(posedge clk) disable iff (rst)
    (state == S_MSG) |-> (32'(msg_cnt) <= pdc_pkg::MAX_MSGS)) else $error("too many messages");
`endif

endmodule

// ===== test/page_directory_coherence_checker.sv =====
`timescale 1ns / 100ps

module page_directory_coherence_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_ready,
  input  pdc_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  pdc_pkg::out_t out_data,
  input  logic          cfg_valid,
  input  logic          cfg_ready,
  input  logic [0:0]    cfg_index,
  input  logic [3:0]    cfg_data,
  output int            errors,
  output int            pending,
  output int            results
);

  localparam int DEPTH = 128;

  logic [2:0]    my_node;
  logic [3:0]    node_count;
  logic          slot_used [DEPTH];
  logic [1:0]    coh_state [DEPTH];
  logic [7:0]    presence [DEPTH];
  logic [19:0]   page_bytes [DEPTH];
  pdc_pkg::out_t expected_q[$];

  assign pending = expected_q.size();

  function automatic void push_reply(int slot, logic data);
    pdc_pkg::out_t r;
    r = '0;
    r.result_kind = pdc_pkg::KIND_REPLY;
    r.page_state = coh_state[slot];
    r.page_size = page_bytes[slot];
    r.valid_here = presence[slot][my_node];
    r.send_data = data;
    r.last = 1'b1;
    expected_q.push_back(r);
  endfunction

  function automatic void push_signal(logic [10:0] code);
    pdc_pkg::out_t r;
    r = '0;
    r.result_kind = pdc_pkg::KIND_SIGNAL;
    r.signal_code = code;
    expected_q.push_back(r);
  endfunction

  function automatic void notify_sharers(int slot, logic [1:0] op, int live);
    pdc_pkg::out_t r;
    int k;
    k = 0;
    for (int i = 0; i < live; i++) begin
      if (k < pdc_pkg::MAX_MSGS && i != my_node && presence[slot][i]) begin
        r = '0;
        r.result_kind = pdc_pkg::KIND_NET;
        r.net_op = op;
        r.target_node = 3'(i);
        expected_q.push_back(r);
        k++;
      end
    end
  endfunction

  function automatic void predict(pdc_pkg::in_t it);
    logic [7:0] me;
    logic [8:0] live_mask;
    int live;
    int slot;
    pdc_pkg::out_t r;
    slot = it.page;
    me = 8'd1 << my_node;
    live = (node_count > 8) ? 8 : node_count;
    live_mask = (9'd1 << live) - 9'd1;
    if (pdc_pkg::opcode_t'(it.opcode) != pdc_pkg::OP_ALLOC && !slot_used[slot]) begin
      r = '0;
      r.last = 1'b1;
      expected_q.push_back(r);
      return;
    end
    case (pdc_pkg::opcode_t'(it.opcode))
      pdc_pkg::OP_ALLOC: begin
        slot_used[slot] = 1'b1;
        presence[slot] = it.peer_presence & live_mask[7:0] & ~me;
        if (it.peer_size == '0) begin
          presence[slot] |= me;
          coh_state[slot] = pdc_pkg::ST_RW;
          page_bytes[slot] = it.req_size;
        end else begin
          coh_state[slot] = pdc_pkg::ST_INV;
          page_bytes[slot] = it.peer_size;
        end
        push_reply(slot, 1'b0);
      end
      pdc_pkg::OP_FREE: begin
        slot_used[slot] = 1'b0;
        r = '0;
        r.last = 1'b1;
        expected_q.push_back(r);
      end
      pdc_pkg::OP_QUERY: push_reply(slot, 1'b0);
      pdc_pkg::OP_LREAD: begin
        notify_sharers(slot, pdc_pkg::NET_READ, live);
        presence[slot] |= me;
        coh_state[slot] = pdc_pkg::ST_RO;
        push_reply(slot, 1'b0);
      end
      pdc_pkg::OP_LWRITE: begin
        notify_sharers(slot, (coh_state[slot] == pdc_pkg::ST_RO) ? pdc_pkg::NET_INV
                                                                 : pdc_pkg::NET_RDEX, live);
        presence[slot] = me;
        coh_state[slot] = pdc_pkg::ST_RW;
        push_reply(slot, 1'b0);
      end
      pdc_pkg::OP_RREAD: begin
        presence[slot][it.from_node] = 1'b1;
        if (coh_state[slot] != pdc_pkg::ST_RO) begin
          coh_state[slot] = pdc_pkg::ST_RO;
          push_signal(pdc_pkg::SIG_RO + 11'(10 * slot));
        end
        push_reply(slot, 1'b1);
      end
      default: begin
        presence[slot] = 8'd1 << it.from_node;
        coh_state[slot] = pdc_pkg::ST_INV;
        push_signal(pdc_pkg::SIG_INV + 11'(10 * slot));
        push_reply(slot, pdc_pkg::opcode_t'(it.opcode) == pdc_pkg::OP_RRDEX);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    pdc_pkg::out_t want;
    if (rst) begin
      my_node <= 3'd1;
      node_count <= 4'd1;
      for (int i = 0; i < DEPTH; i++) slot_used[i] = 1'b0;
      expected_q.delete();
      errors <= 0;
      results <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pdc_pkg::CFG_MY_NODE) my_node <= cfg_data[2:0];
        else node_count <= cfg_data;
      end
      if (in_valid && in_ready) predict(in_data);
      if (out_valid && out_ready) begin
        results <= results + 1;
        if (expected_q.size() == 0) begin
          if (errors < 10) $display("unexpected result %p", out_data);
          errors <= errors + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.result_kind !== out_data.result_kind || want.net_op !== out_data.net_op ||
              want.target_node !== out_data.target_node ||
              want.page_state !== out_data.page_state ||
              want.page_size !== out_data.page_size ||
              want.valid_here !== out_data.valid_here ||
              want.signal_code !== out_data.signal_code ||
              want.send_data !== out_data.send_data || want.last !== out_data.last) begin
            if (errors < 10) $display("mismatch: expected %p, got %p", want, out_data);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ===== test/page_directory_coherence_unit_test.sv =====
`timescale 1ns / 100ps

module page_directory_coherence_unit_test;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_ready;
  pdc_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  pdc_pkg::out_t out_data;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [0:0]    cfg_index;
  logic [3:0]    cfg_data;
  int            errors;
  int            pending;
  int            results;
  int            burst_left;
  int            sent;
  int            hold_request;
  int            hold_served;
  int            hold_count;
  int            rx_cycle;

  page_directory_coherence_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  page_directory_coherence_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .results(results)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // receiver: long hold on request, otherwise rotating stall pattern
  initial begin
    out_ready = 1'b0;
    hold_served = 0;
    hold_count = 0;
    rx_cycle = 0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (hold_request != hold_served) begin
        hold_served = hold_request;
        hold_count = 400;
      end
      if (hold_count > 0) begin
        hold_count--;
        out_ready <= 1'b0;
      end else begin
        case ((rx_cycle / 64) % 3)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 1);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send(pdc_pkg::in_t it);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    burst_left--;
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [3:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic pdc_pkg::in_t make_item(pdc_pkg::opcode_t op, logic [6:0] page,
                                             logic [2:0] from, logic [19:0] req,
                                             logic [19:0] peer, logic [7:0] pres);
    pdc_pkg::in_t it;
    it.opcode = op;
    it.page = page;
    it.from_node = from;
    it.req_size = req;
    it.peer_size = peer;
    it.peer_presence = pres;
    return it;
  endfunction

  function automatic pdc_pkg::in_t random_item();
    pdc_pkg::in_t it;
    int r;
    it = pdc_pkg::in_t'(61'({$urandom, $urandom}));
    r = $urandom_range(0, 99);
    if (r < 18) it.opcode = pdc_pkg::OP_ALLOC;
    else if (r < 24) it.opcode = pdc_pkg::OP_FREE;
    else if (r < 34) it.opcode = pdc_pkg::OP_QUERY;
    else if (r < 52) it.opcode = pdc_pkg::OP_LREAD;
    else if (r < 68) it.opcode = pdc_pkg::OP_LWRITE;
    else if (r < 80) it.opcode = pdc_pkg::OP_RREAD;
    else if (r < 90) it.opcode = pdc_pkg::OP_RINV;
    else it.opcode = pdc_pkg::OP_RRDEX;
    if ($urandom_range(0, 99) < 85) it.page = 7'($urandom_range(0, 15));
    if ($urandom_range(0, 1) == 0) it.peer_size = '0;
    return it;
  endfunction

  initial begin
    logic [3:0] node_sets [5][2];
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_request = 0;
    burst_left = 0;
    sent = 0;
    node_sets = '{'{4'd7, 4'd15}, '{4'd3, 4'd0}, '{4'd5, 4'd4}, '{4'd2, 4'd9},
                  '{4'd1, 4'd1}};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_reg(pdc_pkg::CFG_MY_NODE, 4'd0);
    write_reg(pdc_pkg::CFG_NODE_COUNT, 4'd8);
    send(make_item(pdc_pkg::OP_ALLOC, 7'd0, 3'd0, 20'hFFFFF, 20'd0, 8'hFF));
    send(make_item(pdc_pkg::OP_ALLOC, 7'd127, 3'd0, 20'd0, 20'hFFFFF, 8'hFF));
    send(make_item(pdc_pkg::OP_QUERY, 7'd127, 3'd0, 20'd0, 20'd0, 8'd0));
    send(make_item(pdc_pkg::OP_LREAD, 7'd0, 3'd0, 20'd0, 20'd0, 8'd0));
    send(make_item(pdc_pkg::OP_LWRITE, 7'd0, 3'd0, 20'd0, 20'd0, 8'd0));
    send(make_item(pdc_pkg::OP_LREAD, 7'd127, 3'd0, 20'd0, 20'd0, 8'd0));
    send(make_item(pdc_pkg::OP_LWRITE, 7'd127, 3'd0, 20'd0, 20'd0, 8'd0));
    send(make_item(pdc_pkg::OP_RREAD, 7'd0, 3'd7, 20'd0, 20'd0, 8'd0));
    send(make_item(pdc_pkg::OP_RREAD, 7'd0, 3'd0, 20'd0, 20'd0, 8'd0));
    send(make_item(pdc_pkg::OP_RINV, 7'd127, 3'd0, 20'd0, 20'd0, 8'd0));
    send(make_item(pdc_pkg::OP_RRDEX, 7'd0, 3'd3, 20'd0, 20'd0, 8'd0));
    send(make_item(pdc_pkg::OP_LWRITE, 7'd127, 3'd0, 20'd0, 20'd0, 8'd0));
    send(make_item(pdc_pkg::OP_ALLOC, 7'd127, 3'd7, 20'h12345, 20'd0, 8'h55));
    send(make_item(pdc_pkg::OP_FREE, 7'd0, 3'd0, 20'd0, 20'd0, 8'd0));
    send(make_item(pdc_pkg::OP_QUERY, 7'd0, 3'd0, 20'd0, 20'd0, 8'd0));
    send(make_item(pdc_pkg::OP_LWRITE, 7'd0, 3'd0, 20'd0, 20'd0, 8'd0));
    send(make_item(pdc_pkg::OP_RREAD, 7'd5, 3'd1, 20'd0, 20'd0, 8'd0));
    send(make_item(pdc_pkg::OP_FREE, 7'd127, 3'd0, 20'd0, 20'd0, 8'd0));
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(pdc_pkg::CFG_MY_NODE, node_sets[ph][0]);
      write_reg(pdc_pkg::CFG_NODE_COUNT, node_sets[ph][1]);
      for (int i = 0; i < 73; i++) begin
        if (ph == 1 && i == 10) hold_request = 1;
        if (ph == 3 && i == 36) drain();
        send(random_item());
      end
      drain();
    end

    $display("%0d input transactions over six node settings, %0d results compared",
             sent, results);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== page_directory_coherence_unit.f =====
src/pdc_pkg.sv
src/pdc_ram.sv
src/page_directory_coherence_unit.sv
test/page_directory_coherence_checker.sv
test/page_directory_coherence_unit_test.sv
